### design/pcomb_pkg.sv
package pcomb_pkg;

  localparam int POS_W   = 24;
  localparam int BOX_W   = 23;
  localparam int MASS_W  = 16;
  localparam int BW_W    = 16;
  localparam int BIN_W   = 10;
  localparam int SUM_W   = 48;
  localparam int MTOT_W  = 21;
  localparam int CFG_W   = 23;
  localparam int CIDX_W  = 3;
  localparam int DVD_W   = 49;
  localparam int DVS_W   = 24;
  localparam int DCNT_W  = 6;
  localparam int P_W     = 26;
  localparam int PROD_W  = 43;

  localparam int DEF_MAX_ATOMS = 16;
  localparam int DEF_NUM_BINS  = 1024;

  localparam logic [CIDX_W-1:0] CFG_BOX_X = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BOX_Y = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BOX_Z = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_PMASK = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BINW  = 3'd4;

  typedef enum logic [1:0] {
    OP_WRAP,
    OP_BIN,
    OP_COM
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS,
    ST_WDIV,
    ST_MUL,
    ST_ACC,
    ST_MASS,
    ST_BIN,
    ST_BDIV,
    ST_COM,
    ST_CDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic [1:0] axis;
    logic       phase;
    op_t        op;
    logic       div_start;
    logic       capture;
    logic       p_pos;
    logic       mul;
    logic       acc;
    logic       mass_add;
    logic       bin_neg;
    logic       com_ref;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] wrap_en;
    logic       full;
    logic       z_neg;
    logic       com_z_neg;
    logic       mass_zero;
    logic       last;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

### design/periodic_center_of_mass_binner.sv
// Periodic center-of-mass binner.
// Input channel (in_valid/in_ready): one atom word per handshake, with
// position, mass and a last_atom flag closing each molecule.
// Output channel (out_valid/out_ready): one result word per atom with the
// atom's z bin; on a molecule's last atom it also carries the center of
// mass and its z bin, with com_valid set.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes,
// done by the user only while the block is idle; the block does not enforce it.
// One atom is processed at a time by a shared radix-2 restoring divider.
// The divider produces one quotient bit per cycle. A molecule's last atom
// also runs the center-of-mass divisions and the center's bin. A new atom
// is accepted only once the previous atom has loaded its result register.
// Reset: config and control registers return to defaults, the next atom starts a molecule.
// A stalled receiver holds the result register; the next atom is still
// accepted and processed, and waits before its own output load.
module periodic_center_of_mass_binner #(
  parameter int MAX_ATOMS_PER_MOLECULE = pcomb_pkg::DEF_MAX_ATOMS,
  parameter int NUM_BINS               = pcomb_pkg::DEF_NUM_BINS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pcomb_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [pcomb_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pcomb_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [pcomb_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [pcomb_pkg::POS_W-1:0]  in_pos_z,
  input  logic [pcomb_pkg::MASS_W-1:0]        in_atom_mass,
  input  logic                                in_last_atom,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcomb_pkg::BIN_W-1:0]         out_atom_bin,
  output logic                                out_atom_bin_out_of_range,
  output logic                                out_com_valid,
  output logic signed [pcomb_pkg::POS_W-1:0]  out_com_x,
  output logic signed [pcomb_pkg::POS_W-1:0]  out_com_y,
  output logic signed [pcomb_pkg::POS_W-1:0]  out_com_z,
  output logic [pcomb_pkg::BIN_W-1:0]         out_com_bin,
  output logic                                out_com_bin_out_of_range
);
  import pcomb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcomb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcomb_datapath #(
    .MAX_ATOMS_PER_MOLECULE (MAX_ATOMS_PER_MOLECULE),
    .NUM_BINS               (NUM_BINS)
  ) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .in_pos_x                  (in_pos_x),
    .in_pos_y                  (in_pos_y),
    .in_pos_z                  (in_pos_z),
    .in_atom_mass              (in_atom_mass),
    .in_last_atom              (in_last_atom),
    .out_ready                 (out_ready),
    .out_valid                 (out_valid),
    .out_atom_bin              (out_atom_bin),
    .out_atom_bin_out_of_range (out_atom_bin_out_of_range),
    .out_com_valid             (out_com_valid),
    .out_com_x                 (out_com_x),
    .out_com_y                 (out_com_y),
    .out_com_z                 (out_com_z),
    .out_com_bin               (out_com_bin),
    .out_com_bin_out_of_range  (out_com_bin_out_of_range)
  );

endmodule

### design/pcomb_div.sv
module pcomb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pcomb_pkg::DVD_W-1:0]   dividend,
  input  logic [pcomb_pkg::DVS_W-1:0]   divisor,
  input  logic [pcomb_pkg::DCNT_W-1:0]  steps,
  output logic                          done,
  output logic [pcomb_pkg::DVD_W-1:0]   quot,
  output logic [pcomb_pkg::DVS_W-1:0]   rem
);
  import pcomb_pkg::*;

  logic                busy_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic [DVD_W-1:0]    q_r;
  logic [DVS_W-1:0]    r_r;
  logic [DVS_W-1:0]    d_r;
  logic [DVS_W:0]      trial;
  logic [DVS_W:0]      diff;

  assign trial = {r_r, q_r[DVD_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign done  = busy_r && (cnt_r == '0);
  assign quot  = q_r;
  assign rem   = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r && cnt_r != '0) begin
      if (!diff[DVS_W]) begin
        r_r <= diff[DVS_W-1:0];
        q_r <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        r_r <= trial[DVS_W-1:0];
        q_r <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

### design/pcomb_datapath.sv
module pcomb_datapath #(
  parameter int MAX_ATOMS_PER_MOLECULE = pcomb_pkg::DEF_MAX_ATOMS,
  parameter int NUM_BINS               = pcomb_pkg::DEF_NUM_BINS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcomb_pkg::cmd_t                     cmd,
  output pcomb_pkg::sts_t                     sts,
  input  logic                                cfg_we,
  input  logic [pcomb_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [pcomb_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [pcomb_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [pcomb_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [pcomb_pkg::POS_W-1:0]  in_pos_z,
  input  logic [pcomb_pkg::MASS_W-1:0]        in_atom_mass,
  input  logic                                in_last_atom,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [pcomb_pkg::BIN_W-1:0]         out_atom_bin,
  output logic                                out_atom_bin_out_of_range,
  output logic                                out_com_valid,
  output logic signed [pcomb_pkg::POS_W-1:0]  out_com_x,
  output logic signed [pcomb_pkg::POS_W-1:0]  out_com_y,
  output logic signed [pcomb_pkg::POS_W-1:0]  out_com_z,
  output logic [pcomb_pkg::BIN_W-1:0]         out_com_bin,
  output logic                                out_com_bin_out_of_range
);
  import pcomb_pkg::*;

  localparam int CW = $clog2(MAX_ATOMS_PER_MOLECULE + 1);
  localparam logic [CW-1:0]    MAX_CNT  = CW'(MAX_ATOMS_PER_MOLECULE);
  localparam logic [23:0]      BIN_LAST = 24'(NUM_BINS - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic [BOX_W-1:0]        box_r [3];
  logic [2:0]              pmask_r;
  logic [BW_W-1:0]         bw_r;

  logic signed [POS_W-1:0] pos_r [3];
  logic signed [POS_W-1:0] ref_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [POS_W-1:0] com_r [3];
  logic [MASS_W-1:0]       mass_r;
  logic                    last_r;
  logic                    first_r;
  logic [MTOT_W-1:0]       mtot_r;
  logic [CW-1:0]           cnt_r;
  logic signed [P_W-1:0]   p_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [BIN_W-1:0]        abin_r, cbin_r;
  logic                    aoor_r, coor_r;
  logic                    out_valid_r;

  logic [BIN_W-1:0]        o_abin_r, o_cbin_r;
  logic                    o_aoor_r, o_coor_r, o_cv_r;
  logic signed [POS_W-1:0] o_cx_r, o_cy_r, o_cz_r;

  logic signed [POS_W:0]   d_w;
  logic [POS_W:0]          a_w;
  logic [P_W-1:0]          wdvd;
  logic [BOX_W-1:0]        box_w;
  logic signed [SUM_W-1:0] s_w;
  logic [SUM_W-1:0]        sa_w;
  logic [DVD_W-1:0]        cdvd;
  logic signed [POS_W-1:0] zb_w;
  logic [BW_W-1:0]         wb_w;
  logic [DVD_W-1:0]        dvd;
  logic [DVS_W-1:0]        dvs;
  logic [DCNT_W-1:0]       steps;
  logic                    div_done;
  logic [DVD_W-1:0]        div_quot;
  logic [DVS_W-1:0]        div_rem;
  logic signed [POS_W:0]   rd_w;
  logic signed [P_W-1:0]   rs_w;
  logic signed [P_W-1:0]   pw_w;
  logic signed [SUM_W:0]   sum49;
  logic [MTOT_W:0]         m22;
  logic [23:0]             bq;
  logic                    boor;
  logic signed [POS_W-1:0] cq_w;
  logic signed [MASS_W:0]  mass_s;

  assign box_w = box_r[cmd.axis];
  assign d_w   = {pos_r[cmd.axis][POS_W-1], pos_r[cmd.axis]}
               - {ref_r[cmd.axis][POS_W-1], ref_r[cmd.axis]};
  assign a_w   = d_w[POS_W] ? (POS_W+1)'(-d_w) : d_w;
  assign wdvd  = {a_w, 1'b0} + {3'b0, box_w};
  assign s_w   = sum_r[cmd.axis];
  assign sa_w  = s_w[SUM_W-1] ? SUM_W'(-s_w) : s_w;
  assign cdvd  = {sa_w, 1'b0} + {{(DVD_W-MTOT_W){1'b0}}, mtot_r};
  assign zb_w  = cmd.phase ? com_r[2] : pos_r[2];
  assign wb_w  = (bw_r == '0) ? BW_W'(1) : bw_r;

  always_comb begin
    case (cmd.op)
      OP_WRAP: begin
        dvd   = {wdvd, {(DVD_W-P_W){1'b0}}};
        dvs   = {box_w, 1'b0};
        steps = DCNT_W'(P_W);
      end
      OP_BIN: begin
        dvd   = {zb_w, {(DVD_W-POS_W){1'b0}}};
        dvs   = {{(DVS_W-BW_W){1'b0}}, wb_w};
        steps = DCNT_W'(POS_W);
      end
      OP_COM: begin
        dvd   = cdvd;
        dvs   = {{(DVS_W-MTOT_W-1){1'b0}}, mtot_r, 1'b0};
        steps = DCNT_W'(DVD_W);
      end
      default: begin
        dvd   = '0;
        dvs   = '0;
        steps = '0;
      end
    endcase
  end

  pcomb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .steps    (steps),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // minimum image offset is (rem - box) / 2
  assign rd_w  = $signed({1'b0, div_rem}) - $signed({2'b0, box_w});
  assign rs_w  = $signed({rd_w[POS_W], rd_w}) >>> 1;
  assign pw_w  = {{2{ref_r[cmd.axis][POS_W-1]}}, ref_r[cmd.axis]}
               + (d_w[POS_W] ? -rs_w : rs_w);
  assign mass_s = $signed({1'b0, mass_r});
  assign sum49 = {s_w[SUM_W-1], s_w} + {{(SUM_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign m22   = {1'b0, mtot_r} + {{(MTOT_W+1-MASS_W){1'b0}}, mass_r};
  assign bq    = div_quot[23:0];
  assign boor  = bq > BIN_LAST;

  always_comb begin
    if (s_w[SUM_W-1]) begin
      if (div_quot > DVD_W'(24'h800000)) cq_w = POS_MIN;
      else cq_w = POS_W'(-div_quot[POS_W-1:0]);
    end else begin
      if (div_quot > DVD_W'(24'h7FFFFF)) cq_w = POS_MAX;
      else cq_w = div_quot[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= BOX_W'(4096);
      box_r[1] <= BOX_W'(4096);
      box_r[2] <= BOX_W'(4096);
      pmask_r  <= 3'b111;
      bw_r     <= BW_W'(205);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X: box_r[0] <= cfg_data[BOX_W-1:0];
        CFG_BOX_Y: box_r[1] <= cfg_data[BOX_W-1:0];
        CFG_BOX_Z: box_r[2] <= cfg_data[BOX_W-1:0];
        CFG_PMASK: pmask_r  <= cfg_data[2:0];
        CFG_BINW:  bw_r     <= cfg_data[BW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) first_r <= 1'b0;
      if (cmd.out_load) begin
        first_r     <= last_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      mass_r   <= in_atom_mass;
      last_r   <= in_last_atom;
      if (first_r) begin
        ref_r[0] <= in_pos_x;
        ref_r[1] <= in_pos_y;
        ref_r[2] <= in_pos_z;
        for (int i = 0; i < 3; i++) sum_r[i] <= '0;
        mtot_r <= '0;
        cnt_r  <= '0;
      end
    end
    if (cmd.p_pos) p_r <= {{2{pos_r[cmd.axis][POS_W-1]}}, pos_r[cmd.axis]};
    if (cmd.mul) prod_r <= p_r * mass_s;
    if (cmd.acc) begin
      if (sum49[SUM_W] != sum49[SUM_W-1])
        sum_r[cmd.axis] <= sum49[SUM_W] ? SUM_MIN : SUM_MAX;
      else
        sum_r[cmd.axis] <= sum49[SUM_W-1:0];
    end
    if (cmd.mass_add) begin
      mtot_r <= m22[MTOT_W] ? {MTOT_W{1'b1}} : m22[MTOT_W-1:0];
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.bin_neg) begin
      if (cmd.phase) begin
        cbin_r <= '0;
        coor_r <= 1'b1;
      end else begin
        abin_r <= '0;
        aoor_r <= 1'b1;
      end
    end
    if (cmd.com_ref) com_r[cmd.axis] <= ref_r[cmd.axis];
    if (cmd.capture) begin
      case (cmd.op)
        OP_WRAP: p_r <= pw_w;
        OP_BIN: begin
          if (cmd.phase) begin
            cbin_r <= boor ? BIN_LAST[BIN_W-1:0] : bq[BIN_W-1:0];
            coor_r <= boor;
          end else begin
            abin_r <= boor ? BIN_LAST[BIN_W-1:0] : bq[BIN_W-1:0];
            aoor_r <= boor;
          end
        end
        OP_COM: com_r[cmd.axis] <= cq_w;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      o_abin_r <= abin_r;
      o_aoor_r <= aoor_r;
      o_cv_r   <= last_r;
      o_cx_r   <= last_r ? com_r[0] : '0;
      o_cy_r   <= last_r ? com_r[1] : '0;
      o_cz_r   <= last_r ? com_r[2] : '0;
      o_cbin_r <= last_r ? cbin_r : '0;
      o_coor_r <= last_r & coor_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) sts.wrap_en[i] = pmask_r[i] && (box_r[i] != '0);
    sts.full      = cnt_r >= MAX_CNT;
    sts.z_neg     = pos_r[2][POS_W-1];
    sts.com_z_neg = com_r[2][POS_W-1];
    sts.mass_zero = mtot_r == '0;
    sts.last      = last_r;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid                 = out_valid_r;
  assign out_atom_bin              = o_abin_r;
  assign out_atom_bin_out_of_range = o_aoor_r;
  assign out_com_valid             = o_cv_r;
  assign out_com_x                 = o_cx_r;
  assign out_com_y                 = o_cy_r;
  assign out_com_z                 = o_cz_r;
  assign out_com_bin               = o_cbin_r;
  assign out_com_bin_out_of_range  = o_coor_r;

endmodule

### design/pcomb_ctrl.sv
module pcomb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcomb_pkg::sts_t   sts,
  output pcomb_pkg::cmd_t   cmd
);
  import pcomb_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    phase_nxt = phase_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.phase = phase_r;
    cmd.op    = OP_WRAP;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = '0;
          phase_nxt = 1'b0;
          state_nxt = ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (sts.full) begin
          state_nxt = ST_BIN;
        end else if (sts.wrap_en[axis_r]) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_WDIV;
        end else begin
          cmd.p_pos = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_WDIV: begin
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_MASS;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_AXIS;
        end
      end
      ST_MASS: begin
        cmd.mass_add = 1'b1;
        state_nxt    = ST_BIN;
      end
      ST_BIN, ST_BDIV: begin
        cmd.op = OP_BIN;
        if (state_r == ST_BIN && (phase_r ? sts.com_z_neg : sts.z_neg)) begin
          cmd.bin_neg = 1'b1;
        end else if (state_r == ST_BIN) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_BDIV;
        end else if (sts.div_done) begin
          cmd.capture = 1'b1;
        end
        if (cmd.bin_neg || cmd.capture) begin
          if (!phase_r && sts.last) begin
            axis_nxt  = '0;
            state_nxt = ST_COM;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_COM, ST_CDIV: begin
        cmd.op = OP_COM;
        if (state_r == ST_COM && sts.mass_zero) begin
          cmd.com_ref = 1'b1;
        end else if (state_r == ST_COM) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_CDIV;
        end else if (sts.div_done) begin
          cmd.capture = 1'b1;
        end
        if (cmd.com_ref || cmd.capture) begin
          if (axis_r == 2'd2) begin
            phase_nxt = 1'b1;
            state_nxt = ST_BIN;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_COM;
          end
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
